>>> src/frr_pkg.sv
// Shared types of the fraction reducer: sequencer states and engine status.
`default_nettype none

package frr_pkg;

  // Sequencer states of the reduction engine, one-hot
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIVN = 5'b00100,
    S_DIVD = 5'b01000,
    S_DONE = 5'b10000
  } frr_state_e;

  // Engine status seen by the top level
  typedef struct packed {
    logic idle;  // ready to take a new pair of magnitudes
    logic done;  // quotients are valid and held until acknowledged
  } frr_status_t;

endpackage

`default_nettype wire

>>> src/frr_if.sv
// Valid/ready stream interfaces for the fraction reducer input and result items.
`default_nettype none

interface frr_in_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] numerator;
  logic signed [DATA_WIDTH-1:0] denominator;

  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface frr_out_if #(
  parameter int DATA_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] reduced_numerator;
  logic        [DATA_WIDTH-2:0] reduced_denominator;

  modport source (output valid, reduced_numerator, reduced_denominator, input ready);
  modport sink   (input valid, reduced_numerator, reduced_denominator, output ready);
endinterface

`default_nettype wire

>>> src/fraction_reducer_core.sv
// Fraction reducer top level: sign handling, engine control and output register.
// When either value is zero, the pair goes from idle straight to done and then into the
// output register; otherwise the engine runs a binary GCD, then two restoring divisions
// (numerator, then denominator), then the move into the output register, all on one shared subtractor.
// Throughput: one item at a time; the next item is taken the cycle after the result
// enters the output register, later while a stalled output holds the engine done.
// Reset (rst_ni, async, active low) clears the sequencer and the output valid flag.
`default_nettype none

module fraction_reducer_core #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frr_in_if.sink    in_i,
  frr_out_if.source out_o
);
  import frr_pkg::*;

  localparam int MAG_WIDTH = DATA_WIDTH - 1;

  frr_status_t          status;
  logic                 start;
  logic                 load;
  logic [MAG_WIDTH-1:0] num_mag, den_mag;
  logic [MAG_WIDTH-1:0] qn, qd;
  logic                 neg_q;
  logic                 out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0] rnum_q, rnum_d;
  logic [MAG_WIDTH-1:0]  rden_q;
  logic [DATA_WIDTH-1:0] qn_ext;

  // Magnitude of a signed value, most negative value saturated
  function automatic logic [MAG_WIDTH-1:0] mag_of(input logic [DATA_WIDTH-1:0] raw);
    logic [DATA_WIDTH-1:0] negated;
    negated = ~raw + DATA_WIDTH'(1);
    if (!raw[DATA_WIDTH-1]) begin
      return raw[MAG_WIDTH-1:0];
    end else if (negated[DATA_WIDTH-1]) begin
      return '1;
    end else begin
      return negated[MAG_WIDTH-1:0];
    end
  endfunction

  assign num_mag    = mag_of(in_i.numerator);
  assign den_mag    = mag_of(in_i.denominator);
  assign in_i.ready = status.idle;
  assign start      = in_i.valid & in_i.ready;

  frr_engine #(
    .MAG_WIDTH(MAG_WIDTH)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .num_i   (num_mag),
    .den_i   (den_mag),
    .ack_i   (load),
    .status_o(status),
    .qn_o    (qn),
    .qd_o    (qd)
  );

  // Latch the result sign at accept
  always_ff @(posedge clk_i) begin
    if (start) begin
      neg_q <= in_i.numerator[DATA_WIDTH-1] ^ in_i.denominator[DATA_WIDTH-1];
    end
  end

  // Move a finished result into the output register when it is free
  always_comb begin
    load        = status.done & (~out_valid_q | out_o.ready);
    qn_ext      = {1'b0, qn};
    rnum_d      = neg_q ? (~qn_ext + DATA_WIDTH'(1)) : qn_ext;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rnum_q <= rnum_d;
      rden_q <= qd;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.reduced_numerator   = $signed(rnum_q);
  assign out_o.reduced_denominator = rden_q;

endmodule

`default_nettype wire

>>> src/frr_engine.sv
// Reduction engine: binary GCD and two restoring divisions on one shared subtractor.
`default_nettype none

module frr_engine #(
  parameter int MAG_WIDTH = 31
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [MAG_WIDTH-1:0] num_i,
  input  wire logic [MAG_WIDTH-1:0] den_i,
  input  wire logic                 ack_i,
  output frr_pkg::frr_status_t      status_o,
  output logic      [MAG_WIDTH-1:0] qn_o,
  output logic      [MAG_WIDTH-1:0] qd_o
);
  import frr_pkg::*;

  localparam int KW = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;
  localparam logic [KW-1:0] CNT_LAST = KW'(MAG_WIDTH - 1);

  frr_state_e state_q, state_d;

  logic [MAG_WIDTH-1:0] a_q, a_d, b_q, b_d;
  logic [MAG_WIDTH-1:0] num_q, num_d, den_q, den_d;
  logic [MAG_WIDTH-1:0] g_q, g_d;
  logic [MAG_WIDTH-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [MAG_WIDTH-1:0] qn_q, qn_d, qd_q, qd_d;
  logic [KW-1:0]        k_q, k_d, cnt_q, cnt_d;

  logic                 a_gt;
  logic [MAG_WIDTH:0]   sub_x, sub_y, diff;
  logic                 fits;
  logic [MAG_WIDTH-1:0] div_rem;
  logic [MAG_WIDTH-1:0] div_quo;

  // Shared subtractor: larger minus smaller in GCD, trial subtract in division
  always_comb begin
    a_gt = (a_q > b_q);
    if (state_q == S_GCD) begin
      sub_x = {1'b0, (a_gt ? a_q : b_q)};
      sub_y = {1'b0, (a_gt ? b_q : a_q)};
    end else begin
      sub_x = {rem_q, quo_q[MAG_WIDTH-1]};
      sub_y = {1'b0, g_q};
    end
    diff    = sub_x - sub_y;
    fits    = ~diff[MAG_WIDTH];
    div_rem = fits ? diff[MAG_WIDTH-1:0] : sub_x[MAG_WIDTH-1:0];
    div_quo = {quo_q[MAG_WIDTH-2:0], fits};
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    num_d   = num_q;
    den_d   = den_q;
    g_d     = g_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    qn_d    = qn_q;
    qd_d    = qd_q;
    k_d     = k_q;
    cnt_d   = cnt_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (num_i == '0 || den_i == '0) begin
            // pass zero pairs through untouched
            qn_d    = num_i;
            qd_d    = den_i;
            state_d = S_DONE;
          end else begin
            a_d     = num_i;
            b_d     = den_i;
            num_d   = num_i;
            den_d   = den_i;
            k_d     = '0;
            state_d = S_GCD;
          end
        end
      end

      S_GCD: begin
        if (!a_q[0] && !b_q[0]) begin
          // strip a common factor of two
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + KW'(1);
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (a_q == b_q) begin
          // divisor found; start dividing the numerator
          g_d     = a_q << k_q;
          rem_d   = '0;
          quo_d   = num_q;
          cnt_d   = '0;
          state_d = S_DIVN;
        end else if (a_gt) begin
          a_d = diff[MAG_WIDTH:1];
        end else begin
          b_d = diff[MAG_WIDTH:1];
        end
      end

      S_DIVN: begin
        rem_d = div_rem;
        quo_d = div_quo;
        cnt_d = cnt_q + KW'(1);
        if (cnt_q == CNT_LAST) begin
          qn_d    = div_quo;
          rem_d   = '0;
          quo_d   = den_q;
          cnt_d   = '0;
          state_d = S_DIVD;
        end
      end

      S_DIVD: begin
        rem_d = div_rem;
        quo_d = div_quo;
        cnt_d = cnt_q + KW'(1);
        if (cnt_q == CNT_LAST) begin
          qd_d    = div_quo;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state; only the sequencer state needs reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    num_q <= num_d;
    den_q <= den_d;
    g_q   <= g_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    qn_q  <= qn_d;
    qd_q  <= qd_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
  end

  assign status_o.idle = (state_q == S_IDLE);
  assign status_o.done = (state_q == S_DONE);
  assign qn_o          = qn_q;
  assign qd_o          = qd_q;

`ifndef NO_ASSERTIONS
  // GCD operands never reach zero once both inputs are nonzero
  a_gcd_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_GCD |-> (a_q != '0 && b_q != '0))
    else $error("GCD operand reached zero");

  // Partial remainder stays below the divisor during division
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVN || state_q == S_DIVD) |-> rem_q < g_q)
    else $error("division remainder out of range");

  // Finished quotients hold until acknowledged
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !ack_i) |=>
      (state_q == S_DONE && $stable(qn_q) && $stable(qd_q)))
    else $error("result lost before acknowledge");
`endif

endmodule

`default_nettype wire
